### hdl/hbtm_pkg.sv
// Shared types and constants for the heartbeat timeout monitor.
package hbtm_pkg;

	localparam int MAX_NODES  = 32;
	localparam int NODE_IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int NODE_CNT_W = $clog2(MAX_NODES + 1);

	localparam logic [10:0] HB_BASE_ID    = 11'h700;
	localparam logic [9:0]  TICK_STEP_RST = 10'd1;

	localparam logic [1:0] REQ_SET_TMO   = 2'd0;
	localparam logic [1:0] REQ_HEARTBEAT = 2'd1;
	localparam logic [1:0] REQ_TICK      = 2'd2;

	localparam logic EVT_HEARTBEAT = 1'b0;
	localparam logic EVT_TIMEOUT   = 1'b1;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [6:0]  node_id;
		logic [15:0] timeout_value;
		logic [10:0] cob_id;
		logic [3:0]  data_len;
		logic [7:0]  state_byte;
	} hb_req_t;

	typedef struct packed {
		logic       event_kind;
		logic [6:0] event_node;
		logic [7:0] node_state;
		logic       last_event;
	} hb_evt_t;

	typedef struct packed {
		logic set_tmo;
		logic heartbeat;
		logic tick;
		logic adv;
		logic flush;
	} hbtm_cmd_t;

	typedef struct packed {
		logic out_free;
		logic rd_more;
		logic cmp_vld;
		logic hit;
		logic pend;
	} hbtm_sts_t;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_FLUSH = 3'b100
	} hbtm_state_t;

endpackage

### hdl/heartbeat_timeout_monitor_top.sv
// Top level of the heartbeat timeout monitor: controller plus datapath.
//
//  channel | signals                        | direction | notes
//  --------+--------------------------------+-----------+-------------------------------
//  in      | in_valid, in_ready, in_data    | input     | one request per handshake
//  out     | out_valid, out_ready, out_data | output    | events, last_event ends a request
//  cfg     | cfg_we, cfg_wdata              | input     | tick_step register write
//
// Set-timeout and heartbeat requests need no scan; every request waits for a free output.
// A tick advances the time counter, then scans the nodes: one table read per node
// through the single read port, a pipeline drain and a final flush of a pending timeout.
// Output stalls during a scan hold the scan only when a second timed-out node is waiting.
// Reset clears the counter, tick_step to 1 and all node valid bits at once; no clear pass.
module heartbeat_timeout_monitor_top import hbtm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [9:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  hb_req_t    in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output hb_evt_t    out_data
);

	hbtm_cmd_t cmd;
	hbtm_sts_t sts;

	hbtm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.req_type (in_data.req_type),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	hbtm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

### hdl/hbtm_ctrl.sv
// Controller state machine: request decode, scan sequencing and output stalls.
module hbtm_ctrl import hbtm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] req_type,
	output logic       in_ready,
	input  hbtm_sts_t  sts,
	output hbtm_cmd_t  cmd
);

	hbtm_state_t state_q, state_d;
	logic        acc;

	assign in_ready = (state_q == ST_IDLE) && sts.out_free;
	assign acc      = in_valid && in_ready;

	always_comb begin
		cmd           = '0;
		cmd.set_tmo   = acc && (req_type == REQ_SET_TMO);
		cmd.heartbeat = acc && (req_type == REQ_HEARTBEAT);
		cmd.tick      = acc && (req_type == REQ_TICK);
		// hold the scan when a second hit would need a busy output register
		cmd.adv       = (state_q == ST_SCAN) && !(sts.hit && sts.pend && !sts.out_free);
		cmd.flush     = (state_q == ST_FLUSH) && sts.pend && sts.out_free;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.tick)
					state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (!sts.rd_more && !sts.cmp_vld)
					state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				if (!sts.pend || sts.out_free)
					state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_flush_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH) |-> (!sts.cmp_vld && !sts.rd_more))
		else $error("flush entered with scan still in flight");

	a_tick_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tick |=> (state_q == ST_SCAN))
		else $error("tick did not start a scan");

endmodule

### hdl/hbtm_dp.sv
// Datapath: time counter, node tables, scan pipeline and output register.
module hbtm_dp import hbtm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [9:0] cfg_wdata,
	input  hb_req_t    in_data,
	input  hbtm_cmd_t  cmd,
	output hbtm_sts_t  sts,
	output logic       out_valid,
	input  logic       out_ready,
	output hb_evt_t    out_data
);

	logic [9:0]            tick_step_q;
	logic [31:0]           time_q;
	logic [15:0]           to_mem [MAX_NODES];
	logic [31:0]           ls_mem [MAX_NODES];
	logic [MAX_NODES-1:0]  to_vld_q;
	logic [MAX_NODES-1:0]  ls_vld_q;

	logic [NODE_CNT_W-1:0] rd_cnt_q;
	logic                  cmp_vld_s1;
	logic [NODE_IDX_W-1:0] cmp_idx_s1;
	logic [15:0]           rd_to_s1;
	logic [31:0]           rd_ls_s1;
	logic                  rd_tov_s1;
	logic                  rd_lsv_s1;

	logic                  pend_q;
	logic [6:0]            pend_node_q;
	logic                  out_vld_q;
	hb_evt_t               out_q;

	logic                  set_ok;
	logic [NODE_IDX_W-1:0] set_idx;
	logic [10:0]           hb_off;
	logic                  hb_ok;
	logic [NODE_IDX_W-1:0] hb_idx;
	logic [NODE_IDX_W-1:0] rd_addr;
	logic                  rd_more;
	logic [15:0]           tmo_eff;
	logic [31:0]           elapsed;
	logic                  hit;
	logic [6:0]            cmp_node;
	logic                  out_free;
	logic                  push_hb;
	logic                  push_pend;

	// request decode
	assign set_ok  = (in_data.node_id != 7'd0) && (in_data.node_id <= 7'(MAX_NODES));
	assign set_idx = NODE_IDX_W'(in_data.node_id - 7'd1);
	assign hb_off  = in_data.cob_id - HB_BASE_ID;
	assign hb_ok   = (in_data.data_len == 4'd1) && (in_data.cob_id >= HB_BASE_ID) &&
		(hb_off != 11'd0) && (hb_off <= 11'(MAX_NODES));
	assign hb_idx  = NODE_IDX_W'(hb_off - 11'd1);

	// during a stall the compare entry is read again so its data stays put
	assign rd_more = rd_cnt_q < NODE_CNT_W'(MAX_NODES);
	assign rd_addr = cmd.adv ? rd_cnt_q[NODE_IDX_W-1:0] : cmp_idx_s1;

	assign tmo_eff  = rd_tov_s1 ? rd_to_s1 : 16'd0;
	assign elapsed  = time_q - (rd_lsv_s1 ? rd_ls_s1 : 32'd0);
	assign hit      = cmp_vld_s1 && (tmo_eff != 16'd0) && (elapsed > {16'd0, tmo_eff});
	assign cmp_node = 7'(cmp_idx_s1) + 7'd1;

	assign out_free  = !out_vld_q || out_ready;
	assign push_hb   = cmd.heartbeat && hb_ok;
	assign push_pend = cmd.adv && hit && pend_q;

	always_comb begin
		sts          = '0;
		sts.out_free = out_free;
		sts.rd_more  = rd_more;
		sts.cmp_vld  = cmp_vld_s1;
		sts.hit      = hit;
		sts.pend     = pend_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.set_tmo && set_ok)
			to_mem[set_idx] <= in_data.timeout_value;
		if (push_hb)
			ls_mem[hb_idx] <= time_q;
		rd_to_s1  <= to_mem[rd_addr];
		rd_ls_s1  <= ls_mem[rd_addr];
		rd_tov_s1 <= to_vld_q[rd_addr];
		rd_lsv_s1 <= ls_vld_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.adv && rd_more)
			cmp_idx_s1 <= rd_cnt_q[NODE_IDX_W-1:0];
		if (cmd.adv && hit)
			pend_node_q <= cmp_node;
		if (push_hb)
			out_q <= '{event_kind: EVT_HEARTBEAT, event_node: 7'(hb_off),
				node_state: in_data.state_byte, last_event: 1'b1};
		else if (push_pend)
			out_q <= '{event_kind: EVT_TIMEOUT, event_node: pend_node_q,
				node_state: 8'd0, last_event: 1'b0};
		else if (cmd.flush)
			out_q <= '{event_kind: EVT_TIMEOUT, event_node: pend_node_q,
				node_state: 8'd0, last_event: 1'b1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_step_q <= TICK_STEP_RST;
			time_q      <= '0;
			to_vld_q    <= '0;
			ls_vld_q    <= '0;
			rd_cnt_q    <= '0;
			cmp_vld_s1  <= 1'b0;
			pend_q      <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			if (cfg_we)
				tick_step_q <= cfg_wdata;
			if (cmd.set_tmo && set_ok)
				to_vld_q[set_idx] <= 1'b1;
			if (push_hb)
				ls_vld_q[hb_idx] <= 1'b1;

			if (cmd.tick) begin
				time_q     <= time_q + {22'd0, tick_step_q};
				rd_cnt_q   <= '0;
				cmp_vld_s1 <= 1'b0;
				pend_q     <= 1'b0;
			end else if (cmd.adv) begin
				if (rd_more) begin
					rd_cnt_q   <= rd_cnt_q + NODE_CNT_W'(1);
					cmp_vld_s1 <= 1'b1;
				end else begin
					cmp_vld_s1 <= 1'b0;
				end
				if (hit)
					pend_q <= 1'b1;
			end else if (cmd.flush) begin
				pend_q <= 1'b0;
			end

			if (push_hb || push_pend || cmd.flush)
				out_vld_q <= 1'b1;
			else if (out_ready)
				out_vld_q <= 1'b0;
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(cmp_vld_s1 && !cmd.adv && !cmd.tick) |=> (cmp_vld_s1 && $stable(cmp_idx_s1)))
		else $error("compare entry lost during stall");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_cnt_q <= NODE_CNT_W'(MAX_NODES))
		else $error("scan counter past last node");

	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		(push_hb || push_pend || cmd.flush) |->
		(out_free && $onehot0({push_hb, push_pend, cmd.flush})))
		else $error("event pushed into busy output register");

endmodule
